>>> rtl/urlp_pkg.sv
// Shared types and character constants for the unicode-range list parser.
`timescale 1ns / 1ps

package urlp_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned ValueW = 32;
  localparam int unsigned DigitW = 4;

  localparam logic [CharW-1:0] ChSpace = 8'h20;
  localparam logic [CharW-1:0] ChTab   = 8'h09;
  localparam logic [CharW-1:0] ChNl    = 8'h0a;
  localparam logic [CharW-1:0] ChComma = 8'h2c;
  localparam logic [CharW-1:0] ChPlus  = 8'h2b;
  localparam logic [CharW-1:0] ChDash  = 8'h2d;
  localparam logic [CharW-1:0] ChU     = 8'h75;
  localparam logic [CharW-1:0] ChUpA   = 8'h41;
  localparam logic [CharW-1:0] ChUpZ   = 8'h5a;
  localparam logic [CharW-1:0] ChLowA  = 8'h61;
  localparam logic [CharW-1:0] ChLowF  = 8'h66;
  localparam logic [CharW-1:0] Ch0     = 8'h30;
  localparam logic [CharW-1:0] Ch9     = 8'h39;
  localparam logic [CharW-1:0] CaseOff = 8'h20;
  localparam logic [CharW-1:0] HexTen  = 8'd10;

  typedef enum logic [2:0] {
    PH_LEAD = 3'd0,
    PH_SEP  = 3'd1,
    PH_U    = 3'd2,
    PH_PLUS = 3'd3,
    PH_LOW  = 3'd4,
    PH_DASH = 3'd5,
    PH_HIGH = 3'd6,
    PH_DEAD = 3'd7
  } urlp_phase_t;

  typedef struct packed {
    logic              range_valid;
    logic [ValueW-1:0] range_low;
    logic [ValueW-1:0] range_high;
    logic              list_end;
  } urlp_result_t;

endpackage

>>> rtl/urlp_in_if.sv
// Input channel: one character beat of the range string.
`timescale 1ns / 1ps

interface urlp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

>>> rtl/urlp_out_if.sv
// Result channel: one range beat or end-of-list marker.
`timescale 1ns / 1ps

interface urlp_out_if;
  logic        valid;
  logic        ready;
  logic        range_valid;
  logic [31:0] range_low;
  logic [31:0] range_high;
  logic        list_end;

  modport source (output valid, output range_valid, output range_low,
                  output range_high, output list_end, input ready);
  modport sink   (input valid, input range_valid, input range_low,
                  input range_high, input list_end, output ready);
endinterface

>>> rtl/urlp_core.sv
// Parser state machine: phase and accumulator registers with the per-character step.
`timescale 1ns / 1ps

module urlp_core
  import urlp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [CharW-1:0]   char_code,
  input  logic               last_char,
  output logic               res_valid,
  output urlp_result_t       res,
  output urlp_phase_t        phase
);

  urlp_phase_t       phase_r, phase_nxt, phase_step;
  logic [ValueW-1:0] low_r, low_nxt, high_r, high_nxt;
  logic [CharW-1:0]  ch;
  logic              is_hex;
  logic [DigitW-1:0] dval;
  logic              emit_step;
  logic              emit;
  logic [ValueW-1:0] lo, hi;

  function automatic urlp_phase_t after_entry(input logic [CharW-1:0] c);
    urlp_phase_t p;
    if (c == ChSpace || c == ChComma) p = PH_SEP;
    else if (c == ChU)                p = PH_U;
    else                              p = PH_DEAD;
    return p;
  endfunction

  // Case fold and hex decode.
  always_comb begin
    ch = char_code;
    if (char_code >= ChUpA && char_code <= ChUpZ) ch = char_code + CaseOff;
    is_hex = 1'b0;
    dval   = '0;
    if (ch >= Ch0 && ch <= Ch9) begin
      is_hex = 1'b1;
      dval   = DigitW'(ch - Ch0);
    end else if (ch >= ChLowA && ch <= ChLowF) begin
      is_hex = 1'b1;
      dval   = DigitW'(ch - ChLowA + HexTen);
    end
  end

  // Next phase.
  always_comb begin
    case (phase_r)
      PH_LEAD: begin
        if (ch == ChSpace || ch == ChTab || ch == ChNl) phase_step = PH_LEAD;
        else phase_step = after_entry(ch);
      end
      PH_SEP:  phase_step = after_entry(ch);
      PH_U:    phase_step = (ch == ChPlus) ? PH_PLUS : PH_DEAD;
      PH_PLUS: phase_step = is_hex ? PH_LOW : PH_DEAD;
      PH_LOW: begin
        if (is_hex)            phase_step = PH_LOW;
        else if (ch == ChDash) phase_step = PH_DASH;
        else                   phase_step = after_entry(ch);
      end
      PH_DASH: phase_step = is_hex ? PH_HIGH : PH_DEAD;
      PH_HIGH: phase_step = is_hex ? PH_HIGH : after_entry(ch);
      default: phase_step = PH_DEAD;
    endcase
    phase_nxt = phase_r;
    if (accept) phase_nxt = last_char ? PH_LEAD : phase_step;
  end

  // Accumulators and result.
  always_comb begin
    low_nxt   = low_r;
    high_nxt  = high_r;
    emit_step = 1'b0;
    case (phase_r)
      PH_PLUS: if (is_hex) low_nxt = {{(ValueW-DigitW){1'b0}}, dval};
      PH_LOW: begin
        if (is_hex) low_nxt = {low_r[ValueW-DigitW-1:0], dval};
        else if (ch != ChDash) emit_step = 1'b1;
      end
      PH_DASH: if (is_hex) high_nxt = {{(ValueW-DigitW){1'b0}}, dval};
      PH_HIGH: begin
        if (is_hex) high_nxt = {high_r[ValueW-DigitW-1:0], dval};
        else emit_step = 1'b1;
      end
      default: begin
        low_nxt  = low_r;
        high_nxt = high_r;
      end
    endcase

    emit = emit_step;
    lo   = low_r;
    hi   = (phase_r == PH_HIGH) ? high_r : low_r;
    // The string ending right after entry digits still reports the entry.
    if (last_char && !emit_step) begin
      if (phase_step == PH_LOW) begin
        emit = 1'b1;
        lo   = low_nxt;
        hi   = low_nxt;
      end else if (phase_step == PH_HIGH) begin
        emit = 1'b1;
        lo   = low_nxt;
        hi   = high_nxt;
      end
    end

    res_valid       = accept && (emit || last_char);
    res.range_valid = emit;
    res.range_low   = emit ? lo : '0;
    res.range_high  = emit ? hi : '0;
    res.list_end    = last_char;

    if (!accept) begin
      low_nxt  = low_r;
      high_nxt = high_r;
    end else if (last_char) begin
      low_nxt  = '0;
      high_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEAD;
      low_r   <= '0;
      high_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      low_r   <= low_nxt;
      high_r  <= high_nxt;
    end
  end

  assign phase = phase_r;

endmodule

>>> rtl/urlp_obuf.sv
// Output register stage that holds one result beat while the receiver stalls.
`timescale 1ns / 1ps

module urlp_obuf
  import urlp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         load,
  input  urlp_result_t load_data,
  output logic         can_load,
  output logic         out_valid,
  input  logic         out_ready,
  output urlp_result_t out_data
);

  logic         full_r, full_nxt;
  urlp_result_t data_r;

  // A new result may enter in the same cycle the held one is taken.
  assign can_load = !full_r || out_ready;

  always_comb begin
    full_nxt = full_r;
    if (load)           full_nxt = 1'b1;
    else if (out_ready) full_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) full_r <= 1'b0;
    else        full_r <= full_nxt;
  end

  always_ff @(posedge clk) begin
    if (load) data_r <= load_data;
  end

  assign out_valid = full_r;
  assign out_data  = data_r;

endmodule

>>> rtl/unicode_range_list_parser.sv
// Top level of the unicode-range list parser.
//
// The input channel in_ch carries one character beat per cycle: an ASCII
// byte and a flag on the final character of the string. The parser folds
// case, skips leading whitespace and splits "U+lo" and "U+lo-hi" entries.
// The result channel out_ch carries a beat for each completed range and
// always one beat for the final character, marked list_end; that beat may
// also carry the last range. After a malformed character the rest of the
// string produces nothing until its final character.
// A result appears in the cycle after the character beat that causes it, and
// one character is taken every cycle; throughput is set by the single
// output register. When the receiver stalls with a result held, in_ch.ready
// drops until that result is taken; ready returns combinationally with
// out_ch.ready. Reset clears the parser to its leading-whitespace phase,
// zeroes both accumulators and empties the output register.
`timescale 1ns / 1ps

module unicode_range_list_parser
  import urlp_pkg::*;
(
  input logic            clk,
  input logic            rst_n,
  urlp_in_if.sink        in_ch,
  urlp_out_if.source     out_ch
);

  logic         accept;
  logic         can_load;
  logic         res_valid;
  urlp_result_t res;
  urlp_result_t out_data;
  urlp_phase_t  phase;

  assign in_ch.ready = can_load;
  assign accept      = in_ch.valid && can_load;

  urlp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .char_code (in_ch.char_code),
    .last_char (in_ch.last_char),
    .res_valid (res_valid),
    .res       (res),
    .phase     (phase)
  );

  urlp_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .load_data (res),
    .can_load  (can_load),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_data)
  );

  assign out_ch.range_valid = out_data.range_valid;
  assign out_ch.range_low   = out_data.range_low;
  assign out_ch.range_high  = out_data.range_high;
  assign out_ch.list_end    = out_data.list_end;

`ifndef SYNTHESIS
  // The final character always leaves an end-of-list beat.
  a_last_gives_end: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.last_char |=> out_ch.valid && out_ch.list_end)
    else $error("final character did not produce an end-of-list beat");

  // The parser restarts after the final character.
  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.last_char |=> phase == PH_LEAD)
    else $error("parser did not return to its start phase");

  // A beat without a range carries zero bounds.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.range_valid |->
      out_ch.range_low == '0 && out_ch.range_high == '0)
    else $error("beat without a range has nonzero bounds");
`endif

endmodule
